FILE: rtl/serial_relay_io_controller_assert.svh
// Assertion helpers for the RTL files; only srio_tx.sv includes them.
`ifndef SERIAL_RELAY_IO_CONTROLLER_ASSERT_SVH
`define SERIAL_RELAY_IO_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRIO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srio_pkg.sv
package srio_pkg;

  // Protocol characters
  localparam logic [7:0] CH_START  = 8'h3E;  // '>'
  localparam logic [7:0] CH_STATUS = 8'h73;  // 's'
  localparam logic [7:0] CH_RELAY  = 8'h72;  // 'r'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Position inside the five-beat report
  typedef enum logic [2:0] {
    BEAT_START  = 3'd0,
    BEAT_INPUTS = 3'd1,
    BEAT_RELAYS = 3'd2,
    BEAT_CR     = 3'd3,
    BEAT_LF     = 3'd4
  } beat_t;

  // One held input item
  typedef struct packed {
    logic       action;        // 1 = logic input sample
    logic       rx_error;
    logic [7:0] rx_byte;
    logic [7:0] logic_inputs;
  } in_item_t;

  // Report request handed from the core to the transmitter
  typedef struct packed {
    logic       valid;
    logic [7:0] inputs;
    logic [7:0] relays;
  } rpt_req_t;

endpackage

FILE: rtl/srio_in_reg.sv
module srio_in_reg
  import srio_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [15:0] in_tdata,   // rx_byte [7:0], logic_inputs [15:8]
  input  logic [1:0] in_tuser,   // action [0], rx_error [1]
  input  logic       take,
  output logic       item_vld,
  output in_item_t   item
);

  logic     vld_r;
  in_item_t item_r;

  // Hold one beat; refill when empty or when the core takes the held one
  assign in_tready = !vld_r || take;
  assign item_vld  = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.action       <= in_tuser[0];
      item_r.rx_error     <= in_tuser[1];
      item_r.rx_byte      <= in_tdata[7:0];
      item_r.logic_inputs <= in_tdata[15:8];
    end
  end

endmodule

FILE: rtl/srio_core.sv
module srio_core
  import srio_pkg::*;
#(
  parameter int FRAME_DEPTH = 7
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_vld,
  input  in_item_t item,
  input  logic     slot_free,
  output logic     take,
  output rpt_req_t rpt
);

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_DEPTH - 1);

  logic [7:0]       frame_r [FRAME_DEPTH];
  logic [IDX_W-1:0] wr_idx_r;
  logic             capturing_r;
  logic [7:0]       relay_r;
  logic [7:0]       cur_inputs_r;
  logic [7:0]       rep_inputs_r;

  logic       is_byte, cap_now, store, closed;
  logic [7:0] b0, b1, b2;
  logic       is_status, is_relay, sample_diff, need_rpt;
  logic [7:0] relay_nxt;

  // Decode of the held item against state, with the current byte forwarded
  always_comb begin
    is_byte     = !item.action && !item.rx_error;
    cap_now     = capturing_r || (item.rx_byte == CH_START);
    store       = is_byte && cap_now;
    closed      = is_byte && capturing_r && (item.rx_byte == CH_LF);
    b0 = (store && wr_idx_r == IDX_W'(0)) ? item.rx_byte : frame_r[0];
    b1 = (store && wr_idx_r == IDX_W'(1)) ? item.rx_byte : frame_r[1];
    b2 = (store && wr_idx_r == IDX_W'(2)) ? item.rx_byte : frame_r[2];
    is_status   = (b0 == CH_START) && (b1 == CH_STATUS);
    is_relay    = (b0 == CH_START) && (b1 == CH_RELAY);
    sample_diff = item.action && (item.logic_inputs != rep_inputs_r);
    need_rpt    = sample_diff || (closed && (is_status || is_relay));
    take        = item_vld && (!need_rpt || slot_free);
    relay_nxt   = (closed && is_relay) ? b2 : relay_r;
    rpt.valid   = take && need_rpt;
    rpt.inputs  = item.action ? item.logic_inputs : cur_inputs_r;
    rpt.relays  = relay_nxt;
  end

  // Frame capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_DEPTH; i++) frame_r[i] <= 8'h00;
      wr_idx_r    <= '0;
      capturing_r <= 1'b0;
    end else if (take && is_byte) begin
      if (closed) begin
        for (int i = 0; i < FRAME_DEPTH; i++) frame_r[i] <= 8'h00;
        wr_idx_r    <= '0;
        capturing_r <= 1'b0;
      end else begin
        capturing_r <= cap_now;
        if (store) begin
          frame_r[wr_idx_r] <= item.rx_byte;
          wr_idx_r <= (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + IDX_W'(1);
        end
      end
    end
  end

  // Relays and input tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r      <= 8'h00;
      cur_inputs_r <= 8'h00;
      rep_inputs_r <= 8'h00;
    end else if (take) begin
      relay_r <= relay_nxt;
      if (item.action) begin
        cur_inputs_r <= item.logic_inputs;
        rep_inputs_r <= item.logic_inputs;
      end
    end
  end

endmodule

FILE: rtl/srio_tx.sv
module srio_tx
  import srio_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rpt_req_t   rpt,
  output logic       slot_free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [15:0] out_tdata,  // tx_byte [7:0], relay_outputs [15:8]
  output logic       out_tlast
);

  `include "serial_relay_io_controller_assert.svh"

  logic       busy_r;
  beat_t      beat_r;
  logic [7:0] inputs_r;
  logic [7:0] relays_r;
  logic       fire, last;
  logic [7:0] tx_byte;

  assign fire      = busy_r && out_tready;
  assign last      = (beat_r == BEAT_LF);
  assign slot_free = !busy_r || (fire && last);

  // Report sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= BEAT_START;
    end else if (rpt.valid) begin
      busy_r <= 1'b1;
      beat_r <= BEAT_START;
    end else if (fire) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        beat_r <= beat_t'(beat_r + 3'd1);
      end
    end
  end

  // Report snapshot
  always_ff @(posedge clk) begin
    if (rpt.valid) begin
      inputs_r <= rpt.inputs;
      relays_r <= rpt.relays;
    end
  end

  // Beat payload
  always_comb begin
    case (beat_r)
      BEAT_START:  tx_byte = CH_START;
      BEAT_INPUTS: tx_byte = inputs_r;
      BEAT_RELAYS: tx_byte = relays_r;
      BEAT_CR:     tx_byte = CH_CR;
      BEAT_LF:     tx_byte = CH_LF;
      default:     tx_byte = CH_LF;
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = last;
  assign out_tdata  = {relays_r, tx_byte};

  // Checks
  `SRIO_ASSERT_NOW(a_load_into_free, clk, rst_n, rpt.valid, !busy_r || (fire && last), "report loaded over one in flight")
  `SRIO_ASSERT_NOW(a_beat_range, clk, rst_n, busy_r, beat_r <= BEAT_LF, "beat index out of range")
  `SRIO_ASSERT_NEXT(a_beat_step, clk, rst_n, fire && !last && !rpt.valid, beat_r == beat_t'($past(beat_r) + 3'd1), "beat did not advance")
  `SRIO_ASSERT_NEXT(a_done_idle, clk, rst_n, fire && last && !rpt.valid, !busy_r, "sequencer stayed busy after last beat")

endmodule

FILE: rtl/serial_relay_io_controller.sv
// Channel | Dir | tdata                                  | tuser / tlast
// in_     | in  | rx_byte [7:0], logic_inputs [15:8]     | tuser: action [0], rx_error [1]
// out_    | out | tx_byte [7:0], relay_outputs [15:8]    | tlast: final LF of a report
//
// Each item is decoded combinationally from the input register; a report then
// takes five output beats, so throughput is 1 item per cycle without a report,
// and an item that produces one waits until the report sequencer is free.
// An item passes the input register and loads the report sequencer, which drives the first report beat.
// Synchronous active-low reset clears the frame buffer, relays and input history.
// An item that needs a report waits in the input register while a report is
// still going out; the last beat of a report and the next load overlap.
module serial_relay_io_controller
  import srio_pkg::*;
#(
  parameter int FRAME_DEPTH = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte [7:0], logic_inputs [15:8]
  input  logic [1:0]  in_tuser,   // action [0], rx_error [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // tx_byte [7:0], relay_outputs [15:8]
  output logic        out_tlast
);

  logic     take;
  logic     item_vld;
  in_item_t item;
  logic     slot_free;
  rpt_req_t rpt;

  srio_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  srio_core #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .slot_free (slot_free),
    .take      (take),
    .rpt       (rpt)
  );

  srio_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .rpt        (rpt),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
